@@ rtl/core/lvp_pkg.sv @@
// shared types and constants of the llc voltage regulator with pwm update
// no dependencies; imported by lvp_smul and llc_voltage_pi_pwm_update
`timescale 1ns / 1ps

package lvp_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ADC_BITS  = 12;

  // radix-4 serial multiplier: two multiplier bits retired per cycle
  localparam int DIGIT_W = 2;
  localparam int MPL_W   = 20;                  // widest unsigned gain
  localparam int ERR_W   = 30;                  // |error| stays below 2^29
  localparam int DIFF_W  = ERR_W + 1;
  localparam int PROD_W  = DIFF_W + MPL_W + 1;
  localparam int SUM_W   = PROD_W - FRAC_BITS + 1;
  localparam int OUT_W   = 24;

  localparam int PW_MAX       = 281;
  localparam int PW_MIN       = 204;
  localparam int PERIOD_FLOOR = 450;
  localparam int DB_BASE      = 45;

  // register map, byte address = 4 * index
  localparam int ADDR_W = 5;
  typedef enum logic [2:0] {
    REG_VOLT_GAIN    = 3'd0,
    REG_VOLT_OFFSET  = 3'd1,
    REG_TARGET_VOLTS = 3'd2,
    REG_KP           = 3'd3,
    REG_KI_TS        = 3'd4,
    REG_OUT_MAX      = 3'd5,
    REG_OUT_MIN      = 3'd6,
    REG_WIDTH_CENTER = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_VOLT,
    ST_PROP,
    ST_INTEG,
    ST_CLAMP,
    ST_SHAPE
  } state_t;

  // request to the serial multiplier: acc = init + mcand * mplier
  typedef struct packed {
    logic                     start;
    logic signed [PROD_W-1:0] init;
    logic signed [PROD_W-1:0] mcand;
    logic        [MPL_W-1:0]  mplier;
  } mul_req_t;

endpackage

@@ rtl/core/lvp_smul.sv @@
// radix-4 serial multiply-accumulate unit, signed multiplicand, unsigned multiplier
// depends on lvp_pkg
`timescale 1ns / 1ps

module lvp_smul (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lvp_pkg::mul_req_t                 req,
  output logic                              done,
  output logic signed [lvp_pkg::PROD_W-1:0] prod
);
  import lvp_pkg::*;

  logic signed [PROD_W-1:0] acc_r;
  logic signed [PROD_W-1:0] mc_r;
  logic signed [PROD_W-1:0] mc3_r;
  logic        [MPL_W-1:0]  mp_r;
  logic signed [PROD_W-1:0] addend;

  // finished once no multiplier bits are left
  assign done = (mp_r == '0);
  assign prod = acc_r;

  always_comb begin
    case (mp_r[DIGIT_W-1:0])
      2'd0:    addend = '0;
      2'd1:    addend = mc_r;
      2'd2:    addend = mc_r <<< 1;
      2'd3:    addend = mc3_r;
      default: addend = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mp_r <= '0;
    end else if (req.start) begin
      mp_r <= req.mplier;
    end else if (!done) begin
      mp_r <= mp_r >> DIGIT_W;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc_r <= req.init;
      mc_r  <= req.mcand;
      mc3_r <= req.mcand + (req.mcand <<< 1);
    end else if (!done) begin
      acc_r <= acc_r + addend;
      mc_r  <= mc_r <<< DIGIT_W;
      mc3_r <= mc3_r <<< DIGIT_W;
    end
  end

endmodule

@@ rtl/core/llc_voltage_pi_pwm_update.sv @@
// top level: apb registers, sequencer, incremental pi step and pwm timing
// depends on lvp_pkg and lvp_smul
`timescale 1ns / 1ps

// Each request carries one raw adc conversion of the output voltage and yields
// one result: pwm period, compare, dead band, phase shift and the clamped
// controller output (signed Q16). One request is processed at a time. It passes
// through the single shared radix-4 multiplier, which runs three products in
// turn (scaling, proportional, integral), retires two multiplier bits a cycle
// and stops as soon as the remaining multiplier bits are all zero. A finished
// result sits in the output register, so the next request is accepted while it
// waits; that request's result is held back for as long as the earlier one is
// still stalled in the output register. Registers are written through the apb
// port at byte address 4*index and should only be changed while no request is
// in flight.
module llc_voltage_pi_pwm_update (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [lvp_pkg::ADC_BITS-1:0]         in_adc_sample,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [9:0]                           out_pwm_period,
  output logic [8:0]                           out_pwm_compare,
  output logic [7:0]                           out_dead_band,
  output logic [6:0]                           out_phase_shift,
  output logic signed [lvp_pkg::OUT_W-1:0]     out_drive,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [lvp_pkg::ADDR_W-1:0]           paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);
  import lvp_pkg::*;

  // configuration
  logic [15:0]        volt_gain_r;
  logic signed [20:0] volt_offset_r;
  logic [21:0]        target_volts_r;
  logic [19:0]        kp_r;
  logic [19:0]        ki_ts_r;
  logic [22:0]        out_max_r;
  logic signed [23:0] out_min_r;
  logic [9:0]         width_center_r;

  state_t state_r, state_nxt;

  logic signed [ERR_W-1:0] err_r;
  logic signed [ERR_W-1:0] prev_error_r;
  logic signed [OUT_W-1:0] prev_output_r;
  logic signed [SUM_W-1:0] phi_r;
  logic signed [SUM_W-1:0] sum_r;
  logic signed [OUT_W-1:0] drive_r;

  logic                     out_valid_r;
  logic [9:0]               out_pwm_period_r;
  logic [8:0]               out_pwm_compare_r;
  logic [7:0]               out_dead_band_r;
  logic [6:0]               out_phase_shift_r;
  logic signed [OUT_W-1:0]  out_drive_r;

  mul_req_t                 mul_req;
  logic                     mul_done;
  logic signed [PROD_W-1:0] mul_prod;

  logic                     cfg_wr;
  reg_idx_t                 cfg_idx;
  logic                     in_accept;
  logic                     out_free;
  logic                     out_load;

  logic signed [ERR_W-1:0]  err_now;
  logic signed [DIFF_W-1:0] diff_now;
  logic signed [SUM_W-1:0]  prod_hi;
  logic signed [SUM_W-1:0]  clamp_hi;
  logic signed [SUM_W-1:0]  clamp_lo;
  logic signed [SUM_W-1:0]  upper_cut;
  logic signed [OUT_W-1:0]  drive_nxt;
  logic signed [11:0]       wid_raw;
  logic [8:0]               wid;
  logic [9:0]               period;
  logic [9:0]               period_fl;
  logic [6:0]               phase_nxt;

  // ---------------------------------------------------------------- apb
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      volt_gain_r    <= 16'd866;
      volt_offset_r  <= 21'sd14265;
      target_volts_r <= 22'd1572864;
      kp_r           <= 20'd13107;
      ki_ts_r        <= 20'd16384;
      out_max_r      <= 23'd2621440;
      out_min_r      <= -24'sd2621440;
      width_center_r <= 10'd240;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_VOLT_GAIN:    volt_gain_r    <= pwdata[15:0];
        REG_VOLT_OFFSET:  volt_offset_r  <= pwdata[20:0];
        REG_TARGET_VOLTS: target_volts_r <= pwdata[21:0];
        REG_KP:           kp_r           <= pwdata[19:0];
        REG_KI_TS:        ki_ts_r        <= pwdata[19:0];
        REG_OUT_MAX:      out_max_r      <= pwdata[22:0];
        REG_OUT_MIN:      out_min_r      <= pwdata[23:0];
        REG_WIDTH_CENTER: width_center_r <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_VOLT_GAIN:    prdata = {16'd0, volt_gain_r};
      REG_VOLT_OFFSET:  prdata = {11'd0, volt_offset_r};
      REG_TARGET_VOLTS: prdata = {10'd0, target_volts_r};
      REG_KP:           prdata = {12'd0, kp_r};
      REG_KI_TS:        prdata = {12'd0, ki_ts_r};
      REG_OUT_MAX:      prdata = {9'd0, out_max_r};
      REG_OUT_MIN:      prdata = {8'd0, out_min_r};
      REG_WIDTH_CENTER: prdata = {22'd0, width_center_r};
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- multiplier
  lvp_smul u_smul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  // error never leaves +-2^29, so truncating the product to ERR_W bits loses nothing
  assign err_now  = mul_prod[ERR_W-1:0];
  assign diff_now = DIFF_W'(err_now) - DIFF_W'(prev_error_r);
  assign prod_hi  = {mul_prod[PROD_W-1], mul_prod[PROD_W-1:FRAC_BITS]};

  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_VOLT;
      ST_VOLT:  if (mul_done) state_nxt = ST_PROP;
      ST_PROP:  if (mul_done) state_nxt = ST_INTEG;
      ST_INTEG: if (mul_done) state_nxt = ST_CLAMP;
      ST_CLAMP: state_nxt = ST_SHAPE;
      ST_SHAPE: if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall       = 1'b1;
    out_load       = 1'b0;
    mul_req.start  = 1'b0;
    mul_req.init   = '0;
    mul_req.mcand  = '0;
    mul_req.mplier = '0;
    case (state_r)
      ST_IDLE: begin
        in_stall       = 1'b0;
        // err = target + offset - gain * code, accumulated directly
        mul_req.start  = in_valid;
        mul_req.init   = $signed({{(PROD_W-22){1'b0}}, target_volts_r})
                       + PROD_W'(volt_offset_r);
        mul_req.mcand  = -$signed({{(PROD_W-16){1'b0}}, volt_gain_r});
        mul_req.mplier = {{(MPL_W-ADC_BITS){1'b0}}, in_adc_sample};
      end
      ST_VOLT: begin
        mul_req.start  = mul_done;
        mul_req.mcand  = PROD_W'(diff_now);
        mul_req.mplier = kp_r;
      end
      ST_PROP: begin
        mul_req.start  = mul_done;
        mul_req.mcand  = PROD_W'(err_r);
        mul_req.mplier = ki_ts_r;
      end
      ST_SHAPE: out_load = out_free;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- datapath
  assign clamp_hi  = $signed({{(SUM_W-23){1'b0}}, out_max_r});
  assign clamp_lo  = SUM_W'(out_min_r);
  // upper clamp first, lower one wins when the two cross
  assign upper_cut = (sum_r > clamp_hi) ? clamp_hi : sum_r;
  assign drive_nxt = (upper_cut < clamp_lo) ? out_min_r : upper_cut[OUT_W-1:0];

  // floor(center + drive / 2^16) is the center plus drive shifted right arithmetically by 16
  assign wid_raw = $signed({2'b00, width_center_r})
                 + 12'($signed(drive_r[OUT_W-1:FRAC_BITS]));

  always_comb begin
    if (wid_raw >= 12'sd281)      wid = 9'(PW_MAX);
    else if (wid_raw <= 12'sd204) wid = 9'(PW_MIN);
    else                          wid = wid_raw[8:0];
  end

  assign period    = {wid, 1'b0};
  assign period_fl = (period < 10'(PERIOD_FLOOR)) ? 10'(PERIOD_FLOOR) : period;
  assign phase_nxt = 7'(period_fl - 10'(PERIOD_FLOOR));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_error_r  <= '0;
      prev_output_r <= '0;
    end else if (state_r == ST_CLAMP) begin
      prev_error_r  <= err_r;
      prev_output_r <= drive_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_VOLT && mul_done)  err_r <= err_now;
    if (state_r == ST_PROP && mul_done)  phi_r <= prod_hi + SUM_W'(prev_output_r);
    if (state_r == ST_INTEG && mul_done) sum_r <= phi_r + prod_hi;
    if (state_r == ST_CLAMP)             drive_r <= drive_nxt;
  end

  // ---------------------------------------------------------------- result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pwm_period_r  <= period;
      out_pwm_compare_r <= wid;
      out_phase_shift_r <= phase_nxt;
      out_dead_band_r   <= 8'(phase_nxt) + 8'(DB_BASE);
      out_drive_r       <= drive_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pwm_period  = out_pwm_period_r;
  assign out_pwm_compare = out_pwm_compare_r;
  assign out_dead_band   = out_dead_band_r;
  assign out_phase_shift = out_phase_shift_r;
  assign out_drive       = out_drive_r;

  // ---------------------------------------------------------------- checks
  a_mul_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mul_req.start |-> mul_done)
    else $error("multiplier restarted while busy");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> in_stall)
    else $error("second request taken while one is in flight");

  a_width_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pwm_compare >= 9'd204) && (out_pwm_compare <= 9'd281))
    else $error("pulse width outside clamp range");

  a_timing_tie: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pwm_period == {out_pwm_compare, 1'b0})
               && (out_dead_band == 8'(out_phase_shift) + 8'd45))
    else $error("period, dead band and phase shift disagree");

endmodule
